// ===== hdl/psrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psrf_pkg: shared types and constants for the secant root finder.
// Holds the input and result item structs, the status codes and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package psrf_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF5  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 3'd7;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_STEP_CAP  = 2'd1;
	localparam logic [1:0] ST_FLAT      = 2'd2;

	typedef struct packed {
		logic signed [31:0] x_first;
		logic signed [31:0] x_second;
	} psrf_in_t;

	typedef struct packed {
		logic signed [31:0] root;
		logic [30:0]        residual;
		logic [9:0]         steps_taken;
		logic [1:0]         status;
	} psrf_out_t;

endpackage
`default_nettype wire

// ===== hdl/polynomial_secant_root_finder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_secant_root_finder_unit: secant root finder for a polynomial.
// One shared multiplier, adder and bit-serial divider run under a sequencer.
//
//  channel  | signals                  | handshake
//  ---------+--------------------------+-------------------------------
//  input    | start, busy, in_item     | taken when start & !busy
//  result   | done, out_item           | done high one cycle, no stall
//  config   | cfg_we, cfg_idx, cfg_data| written when cfg_we is high
//
// Each polynomial evaluation runs on the shared multiplier; each secant
// step takes a check, two multiplies, a restoring division, a setup state
// and one evaluation. busy stays high from acceptance until the result
// strobe. Reset returns the sequencer to idle, clears done and loads the
// configuration registers with their reset values. The receiver cannot
// stall; the result shows for one cycle.
// ----------------------------------------------------------------------------
module polynomial_secant_root_finder_unit import psrf_pkg::*; #(
	parameter int MAX_DEGREE = 5,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire psrf_in_t              in_item,
	output logic                       done,
	output psrf_out_t                  out_item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEG_LIM = (MAX_DEGREE < 5) ? MAX_DEGREE : 5;
	localparam logic signed [31:0] TOL = 32'((64'd1 << FRAC_BITS) / 10000);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	typedef enum logic [3:0] {
		S_IDLE, S_EV_POW, S_EV_TERM, S_EV_DONE, S_NUM_A, S_NUM_B,
		S_DIV_SET, S_DIV, S_DIV_END, S_CHECK, S_OUT
	} state_t;

	// Configuration registers.
	logic [2:0]         degree_q;
	logic signed [31:0] coef_q [6];
	logic [9:0]         max_steps_q;

	// Datapath registers.
	state_t             state_q;
	logic [1:0]         ev_tgt_q;
	logic signed [31:0] x1_q, x2_q, x3_q, y1_q, y2_q;
	logic signed [31:0] ev_x_q, pw_q, acc_q;
	logic signed [31:0] pows_q [6];
	logic [2:0]         k_q;
	logic signed [63:0] prod_q;
	logic [9:0]         steps_q;
	logic [1:0]         status_q;
	logic [127:0]       rem_q;
	logic [63:0]        quo_q;
	logic [63:0]        dvs_q;
	logic               neg_q;
	logic [6:0]         cnt_q;

	logic [2:0] eff_deg;
	assign eff_deg = (degree_q > 3'(DEG_LIM)) ? 3'(DEG_LIM) : degree_q;

	logic signed [63:0] rnd_p;
	logic signed [31:0] fx;

	// Shared multiplier operand selection.
	logic signed [31:0] ma, mb;
	logic signed [63:0] mprod;
	always_comb begin
		ma = pw_q;
		mb = ev_x_q;
		case (state_q)
			S_EV_POW:  begin ma = (k_q > 3'd1) ? fx : pw_q; mb = ev_x_q; end
			S_EV_TERM: begin ma = coef_q[k_q]; mb = pows_q[k_q]; end
			S_NUM_A:   begin ma = y2_q; mb = x1_q; end
			S_NUM_B:   begin ma = y1_q; mb = x2_q; end
			default:   begin ma = pw_q; mb = ev_x_q; end
		endcase
		mprod = 64'(ma) * 64'(mb);
	end

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		if (v > SMAX) return 32'sh7FFFFFFF;
		if (v < SMIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	assign rnd_p = (prod_q + RND) >>> FRAC_BITS;
	assign fx = sat(rnd_p);

	logic signed [63:0] acc_sum;
	assign acc_sum = 64'(acc_q) + 64'(fx);

	logic signed [63:0] den;
	assign den = 64'(y2_q) - 64'(y1_q);

	logic signed [63:0] q_s;
	assign q_s = neg_q ? -$signed(quo_q) : $signed(quo_q);

	function automatic logic [30:0] absres(input logic signed [31:0] v);
		if (v == 32'sh80000000) return 31'h7FFFFFFF;
		return v[31] ? 31'(-v) : v[30:0];
	endfunction

	assign busy = (state_q != S_IDLE);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 3'd1;
			max_steps_q <= 10'd64;
			for (int i = 0; i < 6; i++) coef_q[i] <= (i == 1) ? 32'sd65536 : 32'sd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DEGREE: degree_q <= cfg_data[2:0];
				REG_STEPS:  max_steps_q <= cfg_data[9:0];
				default: if (cfg_idx >= REG_COEF0 && cfg_idx <= REG_COEF5)
					coef_q[cfg_idx - REG_COEF0] <= cfg_data;
			endcase
		end
	end

	// Sequencer: evaluate y1, y2, then iterate secant steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					x1_q <= in_item.x_first;
					x2_q <= in_item.x_second;
					ev_x_q <= in_item.x_first;
					ev_tgt_q <= 2'd0;
					steps_q <= '0;
					pw_q <= in_item.x_first;
					pows_q[0] <= ONE;
					pows_q[1] <= in_item.x_first;
					k_q <= 3'd1;
					prod_q <= '0;
					state_q <= S_EV_POW;
				end
				// Build powers: prod_q holds the previous product.
				S_EV_POW: begin
					if (k_q > 3'd1) begin
						pows_q[k_q] <= fx;
						pw_q <= fx;
					end
					if (k_q >= eff_deg) begin
						k_q <= eff_deg;
						acc_q <= '0;
						prod_q <= '0;
						state_q <= (eff_deg == 3'd0) ? S_EV_DONE : S_EV_TERM;
					end else begin
						prod_q <= mprod;
						k_q <= k_q + 3'd1;
					end
				end
				S_EV_TERM: begin
					prod_q <= mprod;
					state_q <= S_EV_DONE;
				end
				S_EV_DONE: begin
					if (k_q != 3'd0) begin
						acc_q <= sat(acc_sum);
						k_q <= k_q - 3'd1;
						state_q <= (k_q == 3'd1) ? S_EV_DONE : S_EV_TERM;
						prod_q <= '0;
					end else begin
						logic signed [31:0] f;
						f = sat(64'(acc_q) + 64'(coef_q[0]));
						case (ev_tgt_q)
							2'd0: begin
								y1_q <= f; ev_x_q <= x2_q; pw_q <= x2_q;
								pows_q[1] <= x2_q; k_q <= 3'd1;
								ev_tgt_q <= 2'd1; state_q <= S_EV_POW;
							end
							2'd1: begin
								y2_q <= f; x3_q <= x2_q; acc_q <= f;
								status_q <= ST_STEP_CAP; state_q <= S_CHECK;
							end
							default: begin
								x1_q <= x2_q; y1_q <= y2_q;
								x2_q <= x3_q; y2_q <= f;
								steps_q <= steps_q + 10'd1;
								acc_q <= f;
								state_q <= (f <= TOL && f >= -TOL) ? S_OUT : S_CHECK;
								status_q <= (f <= TOL && f >= -TOL) ? ST_CONVERGED
									: ST_STEP_CAP;
							end
						endcase
					end
				end
				// Decide whether another step runs.
				S_CHECK: begin
					if (steps_q >= max_steps_q) state_q <= S_OUT;
					else if (den == 0) begin
						status_q <= ST_FLAT; state_q <= S_OUT;
					end else begin
						state_q <= S_NUM_A;
						rem_q <= '0;
					end
				end
				// First numerator product, f(x2) * x1.
				S_NUM_A: begin
					prod_q <= mprod;
					state_q <= S_NUM_B;
				end
				S_NUM_B: begin
					logic signed [63:0] num;
					num = prod_q - mprod;
					neg_q <= num[63] ^ den[63];
					rem_q <= {64'd0, num[63] ? 64'(-num) : num};
					dvs_q <= den[63] ? 64'(-den) : den;
					quo_q <= '0;
					cnt_q <= 7'd64;
					state_q <= S_DIV;
				end
				// Restoring division, one quotient bit per cycle.
				S_DIV: begin
					logic [127:0] r;
					logic [64:0]  t;
					r = rem_q << 1;
					t = {1'b0, r[127:64]} - {1'b0, dvs_q};
					if (!t[64]) begin
						rem_q <= {t[63:0], r[63:0]};
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= r;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) state_q <= S_DIV_END;
				end
				S_DIV_END: begin
					x3_q <= sat(q_s);
					ev_x_q <= sat(q_s);
					pw_q <= sat(q_s);
					pows_q[0] <= ONE;
					pows_q[1] <= sat(q_s);
					k_q <= 3'd1;
					ev_tgt_q <= 2'd2;
					state_q <= S_EV_POW;
				end
				S_OUT: begin
					done <= 1'b1;
					out_item.root <= x2_q;
					out_item.residual <= absres(y2_q);
					out_item.steps_taken <= steps_q;
					out_item.status <= status_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The result strobe only follows a busy cycle.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	// The unit is never busy while a result is being shown.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during done");
	// Status is never the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_item.status != 2'd3) else $error("bad status");

endmodule
`default_nettype wire
